### rtl/assert_macros.svh
// assertion macros used by the checker file bfd_checker.sv
// depends on nothing; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

// antecedent implies consequent (consequent may be a delayed sequence)
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

### rtl/bfd_pkg.sv
// shared constants, types and helpers for the basis-from-direction pipeline
// no dependencies
package bfd_pkg;

   localparam int COMPONENT_BITS_DEF = 16;
   localparam int OUT_W  = 16;
   localparam int QUO_W  = 31;
   localparam int ROOT_W = 16;
   localparam int KW     = ROOT_W - 1;
   localparam int Q14_ONE  = 16384;
   localparam int Q14_HALF = Q14_ONE / 2;
   localparam int FRAC_BITS = 14;

   // cycles through one unit-scaling pipeline
   localparam int UNIT_LAT = 2 + QUO_W + ROOT_W + 1;
   // start beat to result strobe
   localparam int LATENCY = 1 + UNIT_LAT + 1 + UNIT_LAT + 2;

   typedef struct packed {
      logic valid;
      logic zero;
   } unit_status_type;

   // round a q2.28 value (already offset by one half) to q1.14 and clamp
   function automatic logic signed [OUT_W-1:0] sat_q14(input logic signed [32:0] n);
      logic signed [32:0] q;
      q = n >>> FRAC_BITS;
      if (q > 33'sd16384) begin
         return OUT_W'(Q14_ONE);
      end else if (q < -33'sd16384) begin
         return OUT_W'(-Q14_ONE);
      end
      return q[OUT_W-1:0];
   endfunction

endpackage

### rtl/bfd_unit.sv
// pipelined unit scaling of a three-component magnitude vector to q1.14
// depends on bfd_pkg
module bfd_unit #(
   parameter int MAG_W  = bfd_pkg::COMPONENT_BITS_DEF,
   parameter int SIDE_W = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [MAG_W-1:0]        in_mag [3],
   input  logic [SIDE_W-1:0]       in_side,
   output bfd_pkg::unit_status_type out_stat,
   output logic [bfd_pkg::KW-1:0]  out_k [3],
   output logic [SIDE_W-1:0]       out_side
);

   localparam int M2_W = 2 * MAG_W;
   localparam int SW   = M2_W + 2;
   localparam int QW   = bfd_pkg::QUO_W;
   localparam int RTW  = bfd_pkg::ROOT_W;
   localparam int KW   = bfd_pkg::KW;
   localparam int NDIV = QW;
   localparam int NSQ  = RTW;

   // squares
   logic              va_ff;
   logic [SIDE_W-1:0] sidea_ff;
   logic [M2_W-1:0]   sq_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
      end
      sidea_ff <= in_side;
      for (int i = 0; i < 3; i++) begin
         sq_ff[i] <= M2_W'(in_mag[i]) * M2_W'(in_mag[i]);
      end
   end

   // sum of squares and divider seed
   logic              dv_ff    [0:NDIV];
   logic              dz_ff    [0:NDIV];
   logic [SIDE_W-1:0] dside_ff [0:NDIV];
   logic [SW-1:0]     ds_ff    [0:NDIV-1];
   logic [SW-1:0]     drem_ff  [0:NDIV-1][3];
   logic [QW-1:0]     dq_ff    [0:NDIV][3];
   logic              nb_ff    [3];
   logic [SW-1:0]     sum_in;

   assign sum_in = SW'(sq_ff[0]) + SW'(sq_ff[1]) + SW'(sq_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else begin
         dv_ff[0] <= va_ff;
      end
      dz_ff[0]    <= (sum_in == '0);
      dside_ff[0] <= sidea_ff;
      ds_ff[0]    <= sum_in;
      for (int i = 0; i < 3; i++) begin
         drem_ff[0][i] <= SW'(sq_ff[i] >> 1);
         nb_ff[i]      <= sq_ff[i][0];
         dq_ff[0][i]   <= '0;
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar d = 0; d < NDIV; d++) begin : g_div
      logic [SW:0]   trial  [3];
      logic          ge     [3];
      logic [SW-1:0] rem_nx [3];

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            trial[i]  = {drem_ff[d][i], (d == 0) ? nb_ff[i] : 1'b0};
            ge[i]     = trial[i] >= {1'b0, ds_ff[d]};
            rem_nx[i] = ge[i] ? SW'(trial[i] - {1'b0, ds_ff[d]}) : trial[i][SW-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[d+1] <= 1'b0;
         end else begin
            dv_ff[d+1] <= dv_ff[d];
         end
         dz_ff[d+1]    <= dz_ff[d];
         dside_ff[d+1] <= dside_ff[d];
         for (int i = 0; i < 3; i++) begin
            dq_ff[d+1][i] <= {dq_ff[d][i][QW-2:0], ge[i]};
         end
      end

      if (d < NDIV - 1) begin : g_fwd
         always_ff @(posedge clock) begin
            ds_ff[d+1] <= ds_ff[d];
            for (int i = 0; i < 3; i++) begin
               drem_ff[d+1][i] <= rem_nx[i];
            end
         end
      end
   end

   // integer square root, one root bit per stage
   logic              rv_ff    [1:NSQ];
   logic              rz_ff    [1:NSQ];
   logic [SIDE_W-1:0] rside_ff [1:NSQ];
   logic [RTW-1:0]    rt_ff    [1:NSQ][3];
   logic [QW-1:0]     qq_ff    [1:NSQ-1][3];

   for (genvar b = 0; b < NSQ; b++) begin : g_sqrt
      localparam int P = RTW - 1 - b;
      logic              sv;
      logic              sz;
      logic [SIDE_W-1:0] sside;
      logic [QW-1:0]     sq [3];
      logic [RTW-1:0]    srt [3];
      logic [RTW-1:0]    cand [3];
      logic              take [3];

      if (b == 0) begin : g_first
         always_comb begin
            sv    = dv_ff[NDIV];
            sz    = dz_ff[NDIV];
            sside = dside_ff[NDIV];
            for (int i = 0; i < 3; i++) begin
               sq[i]  = dq_ff[NDIV][i];
               srt[i] = '0;
            end
         end
      end else begin : g_next
         always_comb begin
            sv    = rv_ff[b];
            sz    = rz_ff[b];
            sside = rside_ff[b];
            for (int i = 0; i < 3; i++) begin
               sq[i]  = qq_ff[b][i];
               srt[i] = rt_ff[b][i];
            end
         end
      end

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            cand[i] = srt[i] | (RTW'(1) << P);
            take[i] = ((2*RTW)'(cand[i]) * (2*RTW)'(cand[i])) <= (2*RTW)'(sq[i]);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            rv_ff[b+1] <= 1'b0;
         end else begin
            rv_ff[b+1] <= sv;
         end
         rz_ff[b+1]    <= sz;
         rside_ff[b+1] <= sside;
         for (int i = 0; i < 3; i++) begin
            rt_ff[b+1][i] <= take[i] ? cand[i] : srt[i];
         end
      end

      if (b < NSQ - 1) begin : g_fwd
         always_ff @(posedge clock) begin
            for (int i = 0; i < 3; i++) begin
               qq_ff[b+1][i] <= sq[i];
            end
         end
      end
   end

   // k = (root + 1) / 2, zero vector gives zeros
   logic              ov_ff;
   logic              oz_ff;
   logic [SIDE_W-1:0] oside_ff;
   logic [KW-1:0]     ok_ff [3];
   logic [RTW:0]      rinc  [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rinc[i] = {1'b0, rt_ff[NSQ][i]} + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else begin
         ov_ff <= rv_ff[NSQ];
      end
      oz_ff    <= rz_ff[NSQ];
      oside_ff <= rside_ff[NSQ];
      for (int i = 0; i < 3; i++) begin
         ok_ff[i] <= rz_ff[NSQ] ? '0 : rinc[i][KW:1];
      end
   end

   assign out_stat.valid = ov_ff;
   assign out_stat.zero  = oz_ff;
   assign out_k          = ok_ff;
   assign out_side       = oside_ff;

endmodule

### rtl/basis_from_direction.sv
// basis_from_direction: orthonormal frame (u, v, w) from one direction vector
// depends on bfd_pkg and bfd_unit
// start beat to rsp_valid via input reg, u_unit_w, t reg, u_unit_v, product and result regs
// throughput: one beat per cycle; busy is never raised, each unit-scaling
// pipeline retires one vector per cycle through its divider and root stages
// reset: synchronous, clears every valid bit so no strobe follows reset
module basis_from_direction #(
   parameter int COMPONENT_BITS = bfd_pkg::COMPONENT_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [COMPONENT_BITS-1:0]   req_dir_x,
   input  logic signed [COMPONENT_BITS-1:0]   req_dir_y,
   input  logic signed [COMPONENT_BITS-1:0]   req_dir_z,
   output logic                               rsp_valid,
   output logic signed [bfd_pkg::OUT_W-1:0]   rsp_u_x,
   output logic signed [bfd_pkg::OUT_W-1:0]   rsp_u_y,
   output logic signed [bfd_pkg::OUT_W-1:0]   rsp_u_z,
   output logic signed [bfd_pkg::OUT_W-1:0]   rsp_v_x,
   output logic signed [bfd_pkg::OUT_W-1:0]   rsp_v_y,
   output logic signed [bfd_pkg::OUT_W-1:0]   rsp_v_z,
   output logic signed [bfd_pkg::OUT_W-1:0]   rsp_w_x,
   output logic signed [bfd_pkg::OUT_W-1:0]   rsp_w_y,
   output logic signed [bfd_pkg::OUT_W-1:0]   rsp_w_z,
   output logic                               rsp_degenerate
);

   localparam int CB    = COMPONENT_BITS;
   localparam int OW    = bfd_pkg::OUT_W;
   localparam int KW    = bfd_pkg::KW;
   localparam int SIDE2 = 1 + 3 * OW + 3;

   assign busy = 1'b0;

   // input beat: magnitudes and signs
   logic          iv_ff;
   logic [CB-1:0] mag_ff [3];
   logic [2:0]    sgn_ff;
   logic [CB-1:0] raw [3];

   assign raw[0] = req_dir_x;
   assign raw[1] = req_dir_y;
   assign raw[2] = req_dir_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         iv_ff <= 1'b0;
      end else begin
         iv_ff <= start && !busy;
      end
      for (int i = 0; i < 3; i++) begin
         mag_ff[i] <= raw[i][CB-1] ? (~raw[i] + 1'b1) : raw[i];
         sgn_ff[i] <= raw[i][CB-1];
      end
   end

   // scale the direction to w
   bfd_pkg::unit_status_type st1;
   logic [KW-1:0] k1 [3];
   logic [2:0]    s1;

   bfd_unit #(.MAG_W(CB), .SIDE_W(3)) u_unit_w (
      .clock    (clock),
      .reset    (reset),
      .in_valid (iv_ff),
      .in_mag   (mag_ff),
      .in_side  (sgn_ff),
      .out_stat (st1),
      .out_k    (k1),
      .out_side (s1)
   );

   // pick the perpendicular t from |w|, strict compares
   logic                 tv_ff;
   logic                 tdeg_ff;
   logic [KW-1:0]        tm_ff [3];
   logic [2:0]           ts_ff;
   logic signed [OW-1:0] tw_ff [3];
   logic [KW-1:0]        tm_in [3];
   logic [2:0]           ts_in;

   always_comb begin
      if (k1[0] < k1[1] && k1[0] < k1[2]) begin
         tm_in[0] = '0;    tm_in[1] = k1[2]; tm_in[2] = k1[1];
         ts_in    = {~s1[1], s1[2], 1'b0};
      end else if (k1[1] < k1[2]) begin
         tm_in[0] = k1[2]; tm_in[1] = '0;    tm_in[2] = k1[0];
         ts_in    = {~s1[0], 1'b0, s1[2]};
      end else begin
         tm_in[0] = k1[1]; tm_in[1] = k1[0]; tm_in[2] = '0;
         ts_in    = {1'b0, ~s1[0], s1[1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tv_ff <= 1'b0;
      end else begin
         tv_ff <= st1.valid;
      end
      tdeg_ff <= st1.zero;
      ts_ff   <= ts_in;
      for (int i = 0; i < 3; i++) begin
         tm_ff[i] <= tm_in[i];
         tw_ff[i] <= s1[i] ? -OW'(k1[i]) : OW'(k1[i]);
      end
   end

   // scale t to v, w and the flag ride alongside
   bfd_pkg::unit_status_type st2;
   logic [KW-1:0]    k2 [3];
   logic [SIDE2-1:0] side2_in;
   logic [SIDE2-1:0] side2;

   assign side2_in = {tdeg_ff, tw_ff[0], tw_ff[1], tw_ff[2], ts_ff};

   bfd_unit #(.MAG_W(KW), .SIDE_W(SIDE2)) u_unit_v (
      .clock    (clock),
      .reset    (reset),
      .in_valid (tv_ff),
      .in_mag   (tm_ff),
      .in_side  (side2_in),
      .out_stat (st2),
      .out_k    (k2),
      .out_side (side2)
   );

   // unpack and form the six cross products
   logic signed [OW-1:0] vv [3];
   logic signed [OW-1:0] ww [3];
   logic                 deg2;

   assign deg2  = side2[SIDE2-1];
   assign ww[0] = side2[3+3*OW-1 -: OW];
   assign ww[1] = side2[3+2*OW-1 -: OW];
   assign ww[2] = side2[3+OW-1 -: OW];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vv[i] = side2[i] ? -OW'(k2[i]) : OW'(k2[i]);
      end
   end

   logic                 pv_ff;
   logic                 pdeg_ff;
   logic signed [OW-1:0] pv_v_ff [3];
   logic signed [OW-1:0] pv_w_ff [3];
   logic signed [2*OW-1:0] prod_ff [6];

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= st2.valid;
      end
      pdeg_ff    <= deg2;
      pv_v_ff    <= vv;
      pv_w_ff    <= ww;
      prod_ff[0] <= vv[1] * ww[2];
      prod_ff[1] <= vv[2] * ww[1];
      prod_ff[2] <= vv[2] * ww[0];
      prod_ff[3] <= vv[0] * ww[2];
      prod_ff[4] <= vv[0] * ww[1];
      prod_ff[5] <= vv[1] * ww[0];
   end

   // differences, rounding, result register
   logic signed [32:0] diff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff[i] = 33'(prod_ff[2*i]) - 33'(prod_ff[2*i+1]) + 33'sd4096 + 33'sd4096;
      end
   end

   logic                 ov_ff;
   logic                 odeg_ff;
   logic signed [OW-1:0] ou_ff [3];
   logic signed [OW-1:0] ovv_ff [3];
   logic signed [OW-1:0] oww_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else begin
         ov_ff <= pv_ff;
      end
      odeg_ff <= pdeg_ff;
      for (int i = 0; i < 3; i++) begin
         ou_ff[i]  <= pdeg_ff ? '0 : bfd_pkg::sat_q14(diff[i]);
         ovv_ff[i] <= pdeg_ff ? '0 : pv_v_ff[i];
         oww_ff[i] <= pdeg_ff ? '0 : pv_w_ff[i];
      end
   end

   assign rsp_valid      = ov_ff;
   assign rsp_degenerate = odeg_ff;
   assign rsp_u_x        = ou_ff[0];
   assign rsp_u_y        = ou_ff[1];
   assign rsp_u_z        = ou_ff[2];
   assign rsp_v_x        = ovv_ff[0];
   assign rsp_v_y        = ovv_ff[1];
   assign rsp_v_z        = ovv_ff[2];
   assign rsp_w_x        = oww_ff[0];
   assign rsp_w_y        = oww_ff[1];
   assign rsp_w_z        = oww_ff[2];

endmodule

### rtl/bfd_checker.sv
// port-level checks for basis_from_direction, bound to the top level
// depends on bfd_pkg and assert_macros.svh
`include "assert_macros.svh"

module bfd_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_valid,
   input logic signed [bfd_pkg::OUT_W-1:0]  rsp_u_x,
   input logic signed [bfd_pkg::OUT_W-1:0]  rsp_u_y,
   input logic signed [bfd_pkg::OUT_W-1:0]  rsp_u_z,
   input logic signed [bfd_pkg::OUT_W-1:0]  rsp_v_x,
   input logic signed [bfd_pkg::OUT_W-1:0]  rsp_v_y,
   input logic signed [bfd_pkg::OUT_W-1:0]  rsp_v_z,
   input logic signed [bfd_pkg::OUT_W-1:0]  rsp_w_x,
   input logic signed [bfd_pkg::OUT_W-1:0]  rsp_w_y,
   input logic signed [bfd_pkg::OUT_W-1:0]  rsp_w_z,
   input logic                              rsp_degenerate
);

   localparam int LAT = bfd_pkg::LATENCY;
   localparam int ONE = bfd_pkg::Q14_ONE;

   function automatic logic in_unit(input logic signed [bfd_pkg::OUT_W-1:0] c);
      return (c <= ONE) && (c >= -ONE);
   endfunction

   logic accept;
   logic frame_zero;
   logic frame_in_range;

   assign accept = start && !busy;

   // all nine components zero
   assign frame_zero = (rsp_u_x == 0) && (rsp_u_y == 0) && (rsp_u_z == 0) &&
                       (rsp_v_x == 0) && (rsp_v_y == 0) && (rsp_v_z == 0) &&
                       (rsp_w_x == 0) && (rsp_w_y == 0) && (rsp_w_z == 0);

   // all nine components within unit scale
   assign frame_in_range = in_unit(rsp_u_x) && in_unit(rsp_u_y) && in_unit(rsp_u_z) &&
                           in_unit(rsp_v_x) && in_unit(rsp_v_y) && in_unit(rsp_v_z) &&
                           in_unit(rsp_w_x) && in_unit(rsp_w_y) && in_unit(rsp_w_z);

   // every accepted beat yields a strobe after the fixed latency
   `ASSERT_IMPLY(a_latency, clock, reset, accept, ##LAT rsp_valid, "strobe missing after beat")

   // reset leaves no result in flight
   `ASSERT_IMPLY(a_reset_flush, clock, 1'b0, reset, ##1 !rsp_valid, "strobe right after reset")

   // a zero direction comes out as an all-zero frame
   `ASSERT_IMPLY(a_degenerate_zero, clock, reset, rsp_valid && rsp_degenerate, frame_zero, "degenerate not zero")

   // components stay within unit scale
   `ASSERT_IMPLY(a_unit_range, clock, reset, rsp_valid, frame_in_range, "component out of range")

endmodule

bind basis_from_direction bfd_checker u_bfd_checker (.*);
